// File: rtl/core/adsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ADSR envelope package
// Shared types, field widths and constants of the linear ADSR envelope.
// ----------------------------------------------------------------------------
package adsr_pkg;

	localparam int LEVEL_W   = 25;
	localparam int AMP_W     = 17;
	localparam int AMP_LSB   = 8;
	localparam int STAGE_W   = 3;
	localparam int TIME_W    = 16;
	localparam int SUS_W     = 17;
	localparam int CFG_W     = 17;
	localparam int CFG_IDX_W = 2;

	localparam int SAMPLE_RATE_DEFAULT = 48000;
	localparam int SR_W      = 18;
	localparam int MS_PER_S  = 1000;
	localparam int DEN_W     = TIME_W + SR_W;
	localparam int NUM_W     = 35;
	localparam int QUO_W     = 22;
	localparam int DIV_STEPS = QUO_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	localparam logic [LEVEL_W-1:0] ONE_LEVEL   = LEVEL_W'(1) << 24;
	localparam logic [SUS_W-1:0]   SUS_ONE     = SUS_W'(65536);
	localparam logic [TIME_W-1:0]  TIME_RESET  = TIME_W'(500);

	localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 2'd3;

	typedef enum logic [STAGE_W-1:0] {
		ST_ATTACK  = 3'd0,
		ST_DECAY   = 3'd1,
		ST_SUSTAIN = 3'd2,
		ST_RELEASE = 3'd3,
		ST_IDLE    = 3'd4
	} stage_t;

	typedef struct packed {
		logic action;
		logic note_on;
	} adsr_in_t;

	typedef struct packed {
		logic [AMP_W-1:0]   amplitude;
		logic [STAGE_W-1:0] stage;
	} adsr_out_t;

	typedef struct packed {
		logic accept;
		logic load_div;
		logic div_step;
		logic apply_step;
	} adsr_cmd_t;

	typedef struct packed {
		logic makes_result;
		logic needs_step;
	} adsr_status_t;

endpackage
`default_nettype wire

// File: rtl/core/adsr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ADSR envelope controller
// Sequences word acceptance, step division and level update.
// ----------------------------------------------------------------------------
module adsr_ctrl
	import adsr_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  wire logic         out_stall,
	input  wire adsr_status_t status,
	output adsr_cmd_t         cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_MUL,
		S_DIV,
		S_UPD
	} ctrl_state_t;

	ctrl_state_t      state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             accept;
	logic             taken;

	assign in_stall  = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign accept    = in_valid && !in_stall;
	assign taken     = out_valid_q && !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.accept     = accept;
		cmd.load_div   = (state_q == S_MUL);
		cmd.div_step   = (state_q == S_DIV);
		cmd.apply_step = (state_q == S_UPD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept && status.makes_result) begin
				out_valid_q <= 1'b1;
			end else if (taken) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && status.needs_step) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/adsr_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ADSR envelope datapath
// Settings, level and stage registers, step divider and output register.
// ----------------------------------------------------------------------------
module adsr_dp
	import adsr_pkg::*;
#(
	parameter int SAMPLE_RATE_HZ = SAMPLE_RATE_DEFAULT
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire adsr_in_t             in_word,
	input  wire adsr_cmd_t            cmd,
	output adsr_status_t              status,
	output adsr_out_t                 out_word
);

	logic [TIME_W-1:0]  attack_q;
	logic [TIME_W-1:0]  decay_q;
	logic [SUS_W-1:0]   sustain_q;
	logic [TIME_W-1:0]  release_q;
	logic [LEVEL_W-1:0] level_q;
	stage_t             stage_q;
	adsr_out_t          out_word_q;
	logic [DEN_W-1:0]   rem_q;
	logic [DEN_W-1:0]   den_q;
	logic [QUO_W-1:0]   num_lo_q;
	logic [QUO_W-1:0]   quo_q;

	logic [SUS_W-1:0]   sus_clamped;
	logic [LEVEL_W-1:0] sus_lvl;
	logic [LEVEL_W-1:0] span;
	logic [TIME_W-1:0]  time_sel;
	logic [TIME_W-1:0]  time_eff;
	logic [NUM_W-1:0]   num;
	logic [DEN_W-1:0]   den;
	logic [DEN_W:0]     trial;
	logic [DEN_W:0]     diff;
	logic               fits;
	logic [QUO_W-1:0]   step;
	logic [LEVEL_W:0]   sum;
	logic [LEVEL_W-1:0] above_sus;
	stage_t             stage_simple;
	logic [LEVEL_W-1:0] level_next;
	stage_t             stage_next;

	assign sus_clamped = (sustain_q > SUS_ONE) ? SUS_ONE : sustain_q;
	assign sus_lvl     = {sus_clamped, {AMP_LSB{1'b0}}};

	always_comb begin
		case (stage_q)
			ST_ATTACK: begin
				span     = ONE_LEVEL;
				time_sel = attack_q;
			end
			ST_DECAY: begin
				span     = ONE_LEVEL - sus_lvl;
				time_sel = decay_q;
			end
			default: begin
				span     = sus_lvl;
				time_sel = release_q;
			end
		endcase
	end

	assign time_eff = (time_sel == '0) ? TIME_W'(1) : time_sel;
	assign num      = NUM_W'(span) * NUM_W'(MS_PER_S);
	assign den      = DEN_W'(time_eff) * DEN_W'(SAMPLE_RATE_HZ);

	assign trial = {rem_q, num_lo_q[QUO_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = (trial >= {1'b0, den_q});

	assign step = ((quo_q == '0) && (span != '0)) ? QUO_W'(1) : quo_q;

	always_comb begin
		stage_simple     = stage_q;
		status.needs_step = 1'b0;
		case (stage_q)
			ST_ATTACK, ST_DECAY: begin
				if (in_word.note_on) begin
					status.needs_step = 1'b1;
				end else begin
					stage_simple = ST_RELEASE;
				end
			end
			ST_SUSTAIN: begin
				if (!in_word.note_on) begin
					stage_simple = ST_RELEASE;
				end
			end
			ST_RELEASE: begin
				if (in_word.note_on) begin
					stage_simple = ST_ATTACK;
				end else begin
					status.needs_step = 1'b1;
				end
			end
			default: begin
				if (in_word.note_on) begin
					stage_simple = ST_ATTACK;
				end
			end
		endcase
		if (in_word.action) begin
			status.needs_step = 1'b0;
		end
		status.makes_result = !in_word.action;
	end

	assign sum       = {1'b0, level_q} + (LEVEL_W + 1)'(step);
	assign above_sus = level_q - sus_lvl;

	always_comb begin
		level_next = level_q;
		stage_next = stage_q;
		case (stage_q)
			ST_ATTACK: begin
				if (sum >= {1'b0, ONE_LEVEL}) begin
					level_next = ONE_LEVEL;
					stage_next = ST_DECAY;
				end else begin
					level_next = sum[LEVEL_W-1:0];
				end
			end
			ST_DECAY: begin
				if ((level_q <= sus_lvl) || (above_sus <= LEVEL_W'(step))) begin
					level_next = sus_lvl;
					stage_next = ST_SUSTAIN;
				end else begin
					level_next = level_q - LEVEL_W'(step);
				end
			end
			ST_RELEASE: begin
				if (level_q <= LEVEL_W'(step)) begin
					level_next = '0;
					stage_next = ST_IDLE;
				end else begin
					level_next = level_q - LEVEL_W'(step);
				end
			end
			default: begin
				level_next = level_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= TIME_RESET;
			decay_q   <= TIME_RESET;
			sustain_q <= SUS_ONE;
			release_q <= TIME_RESET;
			level_q   <= '0;
			stage_q   <= ST_ATTACK;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_ATTACK:  attack_q  <= cfg_data[TIME_W-1:0];
					CFG_DECAY:   decay_q   <= cfg_data[TIME_W-1:0];
					CFG_SUSTAIN: sustain_q <= cfg_data[SUS_W-1:0];
					CFG_RELEASE: release_q <= cfg_data[TIME_W-1:0];
					default: begin
					end
				endcase
			end
			if (cmd.accept) begin
				if (in_word.action) begin
					level_q <= '0;
					stage_q <= ST_ATTACK;
				end else begin
					stage_q <= stage_simple;
				end
			end else if (cmd.apply_step) begin
				level_q <= level_next;
				stage_q <= stage_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && !in_word.action) begin
			out_word_q.amplitude <= level_q[AMP_LSB +: AMP_W];
			out_word_q.stage     <= stage_q;
		end
		if (cmd.load_div) begin
			rem_q    <= DEN_W'(num[NUM_W-1:QUO_W]);
			num_lo_q <= num[QUO_W-1:0];
			den_q    <= den;
		end else if (cmd.div_step) begin
			rem_q    <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			num_lo_q <= {num_lo_q[QUO_W-2:0], 1'b0};
			quo_q    <= {quo_q[QUO_W-2:0], fits};
		end
	end

	assign out_word = out_word_q;

endmodule
`default_nettype wire

// File: rtl/core/adsr_envelope_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// Latency: the result word of a sample is valid the cycle after the sample is accepted.
// A sample that needs a step (attack or decay with the note held, release with it off)
// holds the input after its acceptance through the product state, 22 divider steps and update.
// Other samples and reset actions do not hold the input; a waiting result stalls the input.
// Reset clears the level to zero, the stage to attack and the settings to their defaults.
// ----------------------------------------------------------------------------
// ADSR envelope generator
// Linear attack, decay, sustain and release envelope, one word per sample that is not a reset action.
// ----------------------------------------------------------------------------
module adsr_envelope_generator
	import adsr_pkg::*;
#(
	parameter int SAMPLE_RATE_HZ = SAMPLE_RATE_DEFAULT
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire adsr_in_t             in_word,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output adsr_out_t                 out_word,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	adsr_cmd_t    cmd;
	adsr_status_t status;

	adsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	adsr_dp #(
		.SAMPLE_RATE_HZ (SAMPLE_RATE_HZ)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_word   (in_word),
		.cmd       (cmd),
		.status    (status),
		.out_word  (out_word)
	);

endmodule
`default_nettype wire

// File: rtl/core/adsr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ADSR envelope port checker
// Checks result delivery and amplitude range on the top-level ports.
// ----------------------------------------------------------------------------
module adsr_checker
	import adsr_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_stall,
	input wire adsr_in_t             in_word,
	input wire logic                 out_valid,
	input wire logic                 out_stall,
	input wire adsr_out_t            out_word,
	input wire logic                 cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_W-1:0]     cfg_data
);

	logic unused_cfg;

	assign unused_cfg = cfg_we ^ (^cfg_index) ^ (^cfg_data);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("result word changed while stalled");

	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !in_word.action |=> out_valid)
		else $error("accepted sample produced no result word");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !(in_valid && !in_stall) |=> !out_valid)
		else $error("result word repeated after being taken");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_word.amplitude <= AMP_W'(65536))
		else $error("amplitude above full scale");

endmodule

bind adsr_envelope_generator adsr_checker u_adsr_checker (.*);
`default_nettype wire
